// ===== src/antialiased_line_raster_defines.svh =====
// Assertion macros shared by the line rasterizer.
`ifndef ANTIALIASED_LINE_RASTER_DEFINES_SVH
`define ANTIALIASED_LINE_RASTER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ALR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ALR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/alr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package alr_pkg;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ColorW = 24;
  localparam int unsigned CountW = 12;
  localparam int unsigned InDataW = 88;
  localparam int unsigned OutDataW = 40;
  localparam logic OpDraw = 1'b0;
  localparam logic OpRead = 1'b1;
endpackage

// ===== src/alr_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module alr_divider #(
  parameter int unsigned NumW = 26,
  parameter int unsigned DenW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;

  // Shift in one numerator bit and try a subtract.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// ===== src/alr_blender.sv =====
// Shared channel blender: one 8-bit channel mixed per use.
module alr_blender #(
  parameter int unsigned FracBits = 16
) (
  input  logic [7:0]        col_i,
  input  logic [7:0]        old_i,
  input  logic [FracBits:0] cov_i,
  output logic [7:0]        mix_o
);
  localparam logic [FracBits:0] One = (FracBits+1)'(1) << FracBits;
  logic [FracBits+9:0] sum;
  logic [FracBits:0]   inv;

  // Weighted sum of the two colors, truncated.
  always_comb begin
    inv = One - cov_i;
    sum = (FracBits+10)'(col_i) * (FracBits+10)'(cov_i)
        + (FracBits+10)'(old_i) * (FracBits+10)'(inv);
    mix_o = sum[FracBits+7:FracBits];
  end
endmodule

// ===== src/antialiased_line_raster.sv =====
// Top level of the antialiased line rasterizer with its framebuffer.
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tuser: operation; tdata: line and read fields
//  m_axis   out  m_axis_tvalid/tready    tdata: pixel_color, count, clipped
// After reset a clearing pass writes one pixel per cycle, over all W*H pixels, before the first beat.
// A read passes through StReadA and StReadB before its result is shown in StOut.
// A draw waits in StDiv for the gradient, then does two blends per major step: an on-screen
// blend goes StPix, StRd, StMix, StWr, StStep; an off-screen blend goes StPix, StStep.
// One memory port and one channel blender, used three times per blend, do the work.
// The result waits in the output register; no beat is taken until it leaves.
module antialiased_line_raster #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation
  input  logic s_axis_tuser,
  // start_x, start_y, end_x, end_y, line_color, read_x, read_y
  input  logic [alr_pkg::InDataW-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_color, pixels_written, clipped
  output logic [alr_pkg::OutDataW-1:0] m_axis_tdata
);
  import alr_pkg::*;
`include "antialiased_line_raster_defines.svh"

  localparam int unsigned Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned NumW  = CoordW + FRAC_BITS;
  localparam int unsigned IcW   = NumW + 2;
  localparam logic [FRAC_BITS:0] CovOne = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef enum logic [10:0] {
    StClear = 11'b00000000001, StIdle = 11'b00000000010, StDiv = 11'b00000000100,
    StPix   = 11'b00000001000, StRd = 11'b00000010000, StMix = 11'b00000100000,
    StWr    = 11'b00001000000, StReadA = 11'b00010000000, StReadB = 11'b00100000000,
    StOut   = 11'b01000000000, StStep = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW:0] clr_q, clr_d;
  logic steep_q, steep_d, neg_q, neg_d, half_q, half_d, clip_q, clip_d;
  logic [CoordW-1:0] maj_q, maj_d, last_q, last_d;
  logic [CoordW-1:0] dmaj_q, dmaj_d;
  logic [IcW-1:0] ic_q, ic_d;
  logic [NumW-1:0] grad_q, grad_d;
  logic [ColorW-1:0] col_q, col_d, old_q, old_d, pix_q, pix_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [1:0] ch_q, ch_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [FRAC_BITS:0] cov_q, cov_d;

  // Command field unpacking.
  logic op;
  logic [CoordW-1:0] sx, sy, ex, ey, rx, ry;
  logic [ColorW-1:0] lcol;
  logic rd_on_screen;
  assign op   = s_axis_tuser;
  assign sx   = s_axis_tdata[9:0];
  assign sy   = s_axis_tdata[19:10];
  assign ex   = s_axis_tdata[29:20];
  assign ey   = s_axis_tdata[39:30];
  assign lcol = s_axis_tdata[63:40];
  assign rx   = s_axis_tdata[73:64];
  assign ry   = s_axis_tdata[83:74];
  assign rd_on_screen = ((CoordW+1)'(rx) < (CoordW+1)'(SCREEN_WIDTH)) &&
                        ((CoordW+1)'(ry) < (CoordW+1)'(SCREEN_HEIGHT));

  // Setup: axis swap and endpoint order.
  logic [CoordW-1:0] adx, ady, a0, b0, a1, b1, ma0, mi0, ma1, mi1;
  logic st_steep;
  always_comb begin
    adx = (ex >= sx) ? ex - sx : sx - ex;
    ady = (ey >= sy) ? ey - sy : sy - ey;
    st_steep = ady > adx;
    a0 = st_steep ? sy : sx;  b0 = st_steep ? sx : sy;
    a1 = st_steep ? ey : ex;  b1 = st_steep ? ex : ey;
    if (a0 > a1) begin
      ma0 = a1; mi0 = b1; ma1 = a0; mi1 = b0;
    end else begin
      ma0 = a0; mi0 = b0; ma1 = a1; mi1 = b1;
    end
  end

  // Gradient divider.
  logic div_start, div_busy;
  logic [NumW-1:0] div_num, quo;
  logic [CoordW-1:0] dmin_abs;
  always_comb begin
    dmin_abs = (mi1 >= mi0) ? mi1 - mi0 : mi0 - mi1;
    div_num = {dmin_abs, FRAC_BITS'(0)};
  end
  alr_divider #(.NumW(NumW), .DenW(CoordW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(ma1 - ma0), .busy_o(div_busy), .quo_o(quo)
  );

  // Shared channel blender.
  logic [7:0] bl_col, bl_old, bl_mix;
  always_comb begin
    case (ch_q)
      2'd0:    begin bl_col = col_q[7:0];   bl_old = old_q[7:0];   end
      2'd1:    begin bl_col = col_q[15:8];  bl_old = old_q[15:8];  end
      default: begin bl_col = col_q[23:16]; bl_old = old_q[23:16]; end
    endcase
  end
  alr_blender #(.FracBits(FRAC_BITS)) u_blend (
    .col_i(bl_col), .old_i(bl_old), .cov_i(cov_q), .mix_o(bl_mix)
  );

  // Framebuffer, one port.
  logic [ColorW-1:0] mem [Depth];
  logic mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [ColorW-1:0] mem_wd, mem_rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_rd_q <= mem[mem_addr];
  end

  // Current pixel coordinates for the blend.
  logic [IcW-1:0] ipx;
  logic [IcW-1:0] minor;
  logic [FRAC_BITS-1:0] frac;
  logic [IcW-1:0] px, py;
  logic on_screen;
  always_comb begin
    ipx   = ic_q >> FRAC_BITS;
    frac  = ic_q[FRAC_BITS-1:0];
    minor = half_q ? ipx : ipx - 1'b1;
    px = steep_q ? minor : IcW'(maj_q);
    py = steep_q ? IcW'(maj_q) : minor;
    on_screen = (px < IcW'(SCREEN_WIDTH)) && (py < IcW'(SCREEN_HEIGHT));
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; clr_d = clr_q; steep_d = steep_q; neg_d = neg_q;
    half_d = half_q; clip_d = clip_q; maj_d = maj_q; last_d = last_q;
    dmaj_d = dmaj_q; ic_d = ic_q; grad_d = grad_q; col_d = col_q;
    old_d = old_q; pix_d = pix_q; cnt_d = cnt_q; ch_d = ch_q;
    addr_d = addr_q; cov_d = cov_q;
    div_start = 1'b0; mem_we = 1'b0; mem_addr = addr_q; mem_wd = old_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1; mem_addr = clr_q[AddrW-1:0]; mem_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(Depth - 1)) state_d = StIdle;
      end
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          pix_d = '0; cnt_d = '0; clip_d = 1'b0;
          if (op == OpRead) begin
            if (rd_on_screen) begin
              addr_d = AddrW'(ry * SCREEN_WIDTH + rx);
              state_d = StReadA;
            end else begin
              clip_d = 1'b1; state_d = StOut;
            end
          end else begin
            steep_d = st_steep; maj_d = ma0; last_d = ma1; dmaj_d = ma1 - ma0;
            neg_d = mi1 < mi0; col_d = lcol;
            ic_d = IcW'(mi0) << FRAC_BITS; half_d = 1'b0;
            div_start = 1'b1; state_d = StDiv;
          end
        end
      end
      StReadA: state_d = StReadB;
      StReadB: begin pix_d = mem_rd_q; state_d = StOut; end
      StDiv: begin
        if (!div_busy) begin
          grad_d = (dmaj_q == '0) ? NumW'(CovOne) : quo;
          state_d = StPix;
        end
      end
      StPix: begin
        cov_d = half_q ? {1'b0, frac} : CovOne - {1'b0, frac};
        if (on_screen) begin
          addr_d = AddrW'(py * SCREEN_WIDTH + px); state_d = StRd;
        end else begin
          clip_d = 1'b1; state_d = StStep;
        end
      end
      StRd: begin
        state_d = StMix; ch_d = 2'd3;
      end
      StMix: begin
        if (ch_q == 2'd3) begin
          old_d = mem_rd_q; ch_d = 2'd0;
        end else begin
          case (ch_q)
            2'd0:    old_d[7:0] = bl_mix;
            2'd1:    old_d[15:8] = bl_mix;
            default: old_d[23:16] = bl_mix;
          endcase
          ch_d = ch_q + 1'b1;
          if (ch_q == 2'd2) state_d = StWr;
        end
      end
      StWr: begin
        mem_we = 1'b1; cnt_d = cnt_q + 1'b1; ch_d = 2'd0; state_d = StStep;
      end
      StStep: begin
        if (!half_q) begin
          half_d = 1'b1; state_d = StPix;
        end else begin
          half_d = 1'b0;
          ic_d = neg_q ? ic_q - IcW'(grad_q) : ic_q + IcW'(grad_q);
          if (maj_q == last_q) state_d = StOut;
          else begin maj_d = maj_q + 1'b1; state_d = StPix; end
        end
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q <= steep_d; neg_q <= neg_d; half_q <= half_d; clip_q <= clip_d;
    maj_q <= maj_d; last_q <= last_d; dmaj_q <= dmaj_d; ic_q <= ic_d;
    grad_q <= grad_d; col_q <= col_d; old_q <= old_d; pix_q <= pix_d;
    cnt_q <= cnt_d; addr_q <= addr_d; cov_q <= cov_d;
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {3'b000, clip_q, cnt_q, pix_q};

  `ALR_ASSERT_IMPL(a_no_in_busy, s_axis_tready, !m_axis_tvalid, "ready while result pending")
  `ALR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `ALR_ASSERT_IMPL(a_div_seq, state_q == StPix, !div_busy, "blend before gradient done")
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the antialiased line rasterizer and its framebuffer.
module tb_top;
  import alr_pkg::*;

  localparam int unsigned ScreenW = 128;
  localparam int unsigned ScreenH = 64;
  localparam int unsigned FracW = 16;
  localparam longint CoverFull = longint'(1) << FracW;
  localparam longint CycleLimit = 20_000_000;

  typedef struct {
    logic op;
    logic [CoordW-1:0] sx, sy, ex, ey;
    logic [ColorW-1:0] color;
    logic [CoordW-1:0] rx, ry;
  } command_t;

  typedef struct {
    logic [ColorW-1:0] pixel;
    logic [CountW-1:0] count;
    logic clip;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // operation
  logic s_axis_tuser = 1'b0;
  // start_x, start_y, end_x, end_y, line_color, read_x, read_y
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // pixel_color, pixels_written, clipped
  logic [OutDataW-1:0] m_axis_tdata;

  logic [ColorW-1:0] frame_model [ScreenW*ScreenH];
  response_t pending_responses [$];
  int unsigned fail_count = 0;
  longint cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  logic hold_request = 1'b0;
  int unsigned stall_mode = 0;

  antialiased_line_raster i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall pattern chosen from four modes, plus a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_left <= 3000;
      hold_request <= 1'b0;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= (cycle_count % 5 != 0);
      endcase
    end
  end

  // Compare each result beat with the oldest predicted response.
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        if (m_axis_tdata[23:0] !== want.pixel) begin
          $display("%0t: pixel_color expected %h actual %h", $time, want.pixel,
                   m_axis_tdata[23:0]);
          fail_count++;
        end
        if (m_axis_tdata[35:24] !== want.count) begin
          $display("%0t: pixels_written expected %0d actual %0d", $time, want.count,
                   m_axis_tdata[35:24]);
          fail_count++;
        end
        if (m_axis_tdata[36] !== want.clip) begin
          $display("%0t: clipped expected %b actual %b", $time, want.clip,
                   m_axis_tdata[36]);
          fail_count++;
        end
      end
    end
  end

  // Blend one pixel into the model framebuffer; returns 0 when off screen.
  function automatic bit blend_pixel(longint col, longint row, longint cov,
                                     logic [ColorW-1:0] color);
    longint idx, mixed;
    logic [ColorW-1:0] old, res;
    if (col < 0 || col >= ScreenW || row < 0 || row >= ScreenH) return 1'b0;
    idx = row * ScreenW + col;
    old = frame_model[idx];
    for (int sh = 0; sh < 24; sh += 8) begin
      mixed = (longint'(color[sh+:8]) * cov + longint'(old[sh+:8]) * (CoverFull - cov))
              >> FracW;
      res[sh+:8] = mixed[7:0];
    end
    frame_model[idx] = res;
    return 1'b1;
  endfunction

  // Work out the response of one command and update the model framebuffer.
  function automatic response_t predict_command(command_t c);
    response_t r;
    longint x0, y0, x1, y1, t, dmaj, dmin, mag, grad, icpt, ip, f;
    bit steep;
    r = '{pixel: '0, count: '0, clip: 1'b0};
    if (c.op == OpRead) begin
      if (c.rx < ScreenW && c.ry < ScreenH) r.pixel = frame_model[c.ry * ScreenW + c.rx];
      else r.clip = 1'b1;
      return r;
    end
    x0 = c.sx; y0 = c.sy; x1 = c.ex; y1 = c.ey;
    steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dmaj = x1 - x0;
    dmin = y1 - y0;
    if (dmaj == 0) begin
      grad = CoverFull;
    end else begin
      mag = ((dmin < 0 ? -dmin : dmin) << FracW) / dmaj;
      grad = dmin < 0 ? -mag : mag;
    end
    icpt = y0 << FracW;
    for (longint m = x0; m <= x1; m++) begin
      ip = icpt >>> FracW;
      f = icpt & (CoverFull - 1);
      for (int k = 0; k < 2; k++) begin
        longint minor, cov;
        minor = (k == 0) ? ip - 1 : ip;
        cov = (k == 0) ? CoverFull - f : f;
        if (steep ? blend_pixel(minor, m, cov, c.color) : blend_pixel(m, minor, cov, c.color))
          r.count++;
        else
          r.clip = 1'b1;
      end
      icpt += grad;
    end
    return r;
  endfunction

  // Offer one command beat and record its response once it is taken.
  task automatic send_command(command_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.op;
    s_axis_tdata <= {4'd0, c.ry, c.rx, c.color, c.ey, c.ex, c.sy, c.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_responses.push_back(predict_command(c));
    // Bursts of random length separated by random gaps.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, int color);
    command_t c;
    c = '{op: OpDraw, sx: CoordW'(sx), sy: CoordW'(sy), ex: CoordW'(ex), ey: CoordW'(ey),
          color: ColorW'(color), rx: CoordW'($urandom), ry: CoordW'($urandom)};
    send_command(c);
  endtask

  task automatic read_pixel(int rx, int ry);
    command_t c;
    c = '{op: OpRead, sx: CoordW'($urandom), sy: CoordW'($urandom),
          ex: CoordW'($urandom), ey: CoordW'($urandom),
          color: ColorW'($urandom), rx: CoordW'(rx), ry: CoordW'(ry)};
    send_command(c);
  endtask

  // Directed cases: empty frame, every slope class, degenerate and off-screen lines.
  task automatic test_directed();
    read_pixel(0, 0);
    read_pixel(ScreenW - 1, ScreenH - 1);
    read_pixel(1023, 1023);
    read_pixel(ScreenW, 0);
    draw_line(5, 10, 60, 10, 24'hFFFFFF);
    draw_line(20, 3, 20, 50, 24'hFF0000);
    draw_line(0, 0, 63, 63, 24'h00FF00);
    draw_line(90, 40, 10, 5, 24'h0000FF);
    draw_line(70, 60, 80, 2, 24'h123456);
    draw_line(33, 33, 33, 33, 24'hABCDEF);
    draw_line(0, 0, ScreenW - 1, 0, 24'h000000);
    draw_line(100, 10, 300, 500, 24'hFFFFFF);
    draw_line(1023, 1023, 1023, 1023, 24'h808080);
    draw_line(0, 1023, 1023, 0, 24'h55AA55);
    draw_line(ScreenW - 1, ScreenH - 1, 0, ScreenH - 2, 24'hC0FFEE);
    read_pixel(10, 9);
    read_pixel(10, 10);
    read_pixel(19, 25);
    read_pixel(32, 32);
    read_pixel(33, 32);
    read_pixel(127, 63);
    read_pixel(0, 1023);
  endtask

  // Random mix of draws and reads, mostly near the screen so lines stay short.
  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 4) hold_request <= 1'b1;
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) < 7)
          read_pixel($urandom_range(0, ScreenW - 1), $urandom_range(0, ScreenH - 1));
        else
          read_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if ($urandom_range(0, 99) < 3) begin
        draw_line($urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      end else begin
        draw_line($urandom_range(0, ScreenW + 8), $urandom_range(0, ScreenH + 8),
                  $urandom_range(0, ScreenW + 8), $urandom_range(0, ScreenH + 8), $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ScreenW * ScreenH; i++) frame_model[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1530);
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
